@@ hdl/rfd_pkg.sv @@
// Package for the RPC frame deframer: shared constants, phase and code enums, result types.
// No dependencies; the parser, the queue and the top level refer to it by scoped names.
package rfd_pkg;

  // Default limits, used as parameter defaults by the top level and the parser.
  parameter int RFD_MAX_FRAME      = 4096;
  parameter int RFD_MSG_ID_MAX     = 100;
  parameter int RFD_TEXT_FIELD_MAX = 512;

  // Bytes of a frame that are not field or payload bytes.
  parameter int RFD_OVERHEAD = 26;

  // Width of the frame length on the result port.
  parameter int RFD_FLEN_W = 13;

  // Reset values of the configuration registers.
  parameter logic [7:0] RFD_START_RST = 8'd2;
  parameter logic [7:0] RFD_END_RST   = 8'd3;

  // Configuration register indexes.
  parameter logic RFD_REG_START = 1'b0;
  parameter logic RFD_REG_END   = 1'b1;

  // Result buffer depth, its pointer width and its level width.
  parameter int RFD_BUF_DEPTH = 3;
  parameter int RFD_BUF_PTR_W = $clog2(RFD_BUF_DEPTH);
  parameter int RFD_BUF_LVL_W = $clog2(RFD_BUF_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_PKLEN,
    PH_IDLEN,
    PH_ID,
    PH_MLEN,
    PH_METH,
    PH_ERRC,
    PH_ELEN,
    PH_EINFO,
    PH_PAYLOAD,
    PH_CSUM,
    PH_ENDB,
    PH_SKIP
  } rfd_phase_e;

  typedef enum logic [2:0] {
    KIND_MSG_ID,
    KIND_METHOD,
    KIND_ERR_INFO,
    KIND_PAYLOAD,
    KIND_FRAME_END
  } rfd_kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_END,
    ST_OVERRUN,
    ST_TOO_LONG
  } rfd_status_e;

  typedef struct packed {
    rfd_kind_e              kind;
    logic [7:0]             data_out;
    logic signed [31:0]     error_code;
    logic [RFD_FLEN_W-1:0]  frame_length;
    rfd_status_e            status;
    logic                   last;
  } rfd_result_t;

  // One result written into the buffer.
  typedef struct packed {
    logic        valid;
    rfd_result_t res;
  } rfd_push_t;

endpackage

@@ hdl/rfd_in_if.sv @@
// Input channel of the RPC frame deframer: one stream byte per item.
// Depends on nothing.
interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;

  modport source (output valid, output data_in, input ready);
  modport sink (input valid, input data_in, output ready);
endinterface

@@ hdl/rfd_out_if.sv @@
// Result channel of the RPC frame deframer: one field byte or frame end per item.
// Depends on nothing.
interface rfd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         data_out;
  logic signed [31:0] error_code;
  logic [12:0]        frame_length;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output kind, output data_out, output error_code,
                  output frame_length, output status, output last, input ready);
  modport sink (input valid, input kind, input data_out, input error_code,
                input frame_length, input status, input last, output ready);
endinterface

@@ hdl/rfd_core.sv @@
// Frame parser of the RPC frame deframer: phase register, counters and one byte step.
// Depends on rfd_pkg.
module rfd_core #(
  parameter int MAX_FRAME      = rfd_pkg::RFD_MAX_FRAME,
  parameter int MSG_ID_MAX     = rfd_pkg::RFD_MSG_ID_MAX,
  parameter int TEXT_FIELD_MAX = rfd_pkg::RFD_TEXT_FIELD_MAX
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                stage_valid_i,
  input  logic [7:0]          stage_data_i,
  input  logic [7:0]          start_byte_i,
  input  logic [7:0]          end_byte_i,
  output rfd_pkg::rfd_push_t  push_o
);

  localparam int LEN_W = $clog2(MAX_FRAME + 1);
  localparam int SUM_W = $clog2(MAX_FRAME + MSG_ID_MAX + TEXT_FIELD_MAX + rfd_pkg::RFD_OVERHEAD + 1);
  localparam logic [31:0] OVH32  = 32'(rfd_pkg::RFD_OVERHEAD);
  localparam logic [31:0] MAX32  = 32'(MAX_FRAME);
  localparam logic [31:0] MSG32  = 32'(MSG_ID_MAX);
  localparam logic [31:0] TEXT32 = 32'(TEXT_FIELD_MAX);

  rfd_pkg::rfd_phase_e  phase_q, phase_d;
  rfd_pkg::rfd_status_e status_q, status_d;
  logic [31:0]      word_q, word_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [LEN_W-1:0] used_q, used_d;
  logic [31:0]      err_q, err_d;

  logic             word_phase;
  logic [31:0]      shift_nxt;
  logic [LEN_W-1:0] left_dec;
  logic             word_done;
  logic [31:0]      store_max;
  logic [SUM_W-1:0] used_sum;
  logic [LEN_W-1:0] used_new;
  logic [LEN_W-1:0] plen_new;
  logic [LEN_W-1:0] plen_old;
  rfd_pkg::rfd_push_t push;

  assign word_phase = (phase_q == rfd_pkg::PH_PKLEN) || (phase_q == rfd_pkg::PH_IDLEN) ||
                      (phase_q == rfd_pkg::PH_MLEN)  || (phase_q == rfd_pkg::PH_ERRC)  ||
                      (phase_q == rfd_pkg::PH_ELEN)  || (phase_q == rfd_pkg::PH_CSUM);
  assign shift_nxt  = {word_q[23:0], stage_data_i};
  assign left_dec   = left_q - LEN_W'(1);
  assign word_done  = word_phase && (left_dec == '0);
  assign store_max  = (phase_q == rfd_pkg::PH_IDLEN) ? MSG32 : TEXT32;
  assign used_sum   = SUM_W'(rfd_pkg::RFD_OVERHEAD) + SUM_W'(used_q) + SUM_W'(shift_nxt);
  assign used_new   = used_q + LEN_W'(shift_nxt);
  assign plen_new   = len_q - LEN_W'(rfd_pkg::RFD_OVERHEAD) - used_new;
  assign plen_old   = len_q - LEN_W'(rfd_pkg::RFD_OVERHEAD) - used_q;

  // Next state for one accepted byte.
  always_comb begin
    phase_d  = phase_q;
    status_d = status_q;
    word_d   = word_q;
    pos_d    = pos_q;
    len_d    = len_q;
    left_d   = left_q;
    used_d   = used_q;
    err_d    = err_q;
    if (stage_valid_i) begin
      if (phase_q == rfd_pkg::PH_HUNT) begin
        if (stage_data_i == start_byte_i) begin
          pos_d    = LEN_W'(1);
          len_d    = '0;
          used_d   = '0;
          err_d    = '0;
          status_d = rfd_pkg::ST_OK;
          phase_d  = rfd_pkg::PH_PKLEN;
          left_d   = LEN_W'(4);
          word_d   = '0;
        end
      end else begin
        pos_d = pos_q + LEN_W'(1);
        if (word_phase) begin
          word_d = shift_nxt;
          left_d = left_dec;
        end
        case (phase_q)
          rfd_pkg::PH_PKLEN: begin
            if (word_done) begin
              if ((shift_nxt < OVH32) || (shift_nxt > MAX32)) begin
                phase_d = rfd_pkg::PH_HUNT;
              end else begin
                len_d   = LEN_W'(shift_nxt);
                phase_d = rfd_pkg::PH_IDLEN;
                left_d  = LEN_W'(4);
                word_d  = '0;
              end
            end
          end
          rfd_pkg::PH_IDLEN, rfd_pkg::PH_MLEN, rfd_pkg::PH_ELEN: begin
            if (word_done) begin
              if (shift_nxt > store_max) begin
                status_d = rfd_pkg::ST_TOO_LONG;
                phase_d  = rfd_pkg::PH_SKIP;
              end else if (used_sum > SUM_W'(len_q)) begin
                status_d = rfd_pkg::ST_OVERRUN;
                phase_d  = rfd_pkg::PH_SKIP;
              end else begin
                used_d = used_new;
                if (shift_nxt != '0) begin
                  left_d = LEN_W'(shift_nxt);
                  case (phase_q)
                    rfd_pkg::PH_IDLEN: phase_d = rfd_pkg::PH_ID;
                    rfd_pkg::PH_MLEN:  phase_d = rfd_pkg::PH_METH;
                    default:           phase_d = rfd_pkg::PH_EINFO;
                  endcase
                end else if (phase_q == rfd_pkg::PH_IDLEN) begin
                  phase_d = rfd_pkg::PH_MLEN;
                  left_d  = LEN_W'(4);
                  word_d  = '0;
                end else if (phase_q == rfd_pkg::PH_MLEN) begin
                  phase_d = rfd_pkg::PH_ERRC;
                  left_d  = LEN_W'(4);
                  word_d  = '0;
                end else if (plen_new != '0) begin
                  phase_d = rfd_pkg::PH_PAYLOAD;
                  left_d  = plen_new;
                end else begin
                  phase_d = rfd_pkg::PH_CSUM;
                  left_d  = LEN_W'(4);
                  word_d  = '0;
                end
              end
            end
          end
          rfd_pkg::PH_ERRC: begin
            if (word_done) begin
              err_d   = shift_nxt;
              phase_d = rfd_pkg::PH_ELEN;
              left_d  = LEN_W'(4);
              word_d  = '0;
            end
          end
          rfd_pkg::PH_CSUM: begin
            if (word_done) begin
              phase_d = rfd_pkg::PH_ENDB;
            end
          end
          rfd_pkg::PH_ID, rfd_pkg::PH_METH, rfd_pkg::PH_EINFO, rfd_pkg::PH_PAYLOAD: begin
            left_d = left_dec;
            if (left_dec == '0) begin
              case (phase_q)
                rfd_pkg::PH_ID: begin
                  phase_d = rfd_pkg::PH_MLEN;
                  left_d  = LEN_W'(4);
                  word_d  = '0;
                end
                rfd_pkg::PH_METH: begin
                  phase_d = rfd_pkg::PH_ERRC;
                  left_d  = LEN_W'(4);
                  word_d  = '0;
                end
                rfd_pkg::PH_EINFO: begin
                  if (plen_old != '0) begin
                    phase_d = rfd_pkg::PH_PAYLOAD;
                    left_d  = plen_old;
                  end else begin
                    phase_d = rfd_pkg::PH_CSUM;
                    left_d  = LEN_W'(4);
                    word_d  = '0;
                  end
                end
                default: begin
                  phase_d = rfd_pkg::PH_CSUM;
                  left_d  = LEN_W'(4);
                  word_d  = '0;
                end
              endcase
            end
          end
          rfd_pkg::PH_ENDB: begin
            if (stage_data_i != end_byte_i) begin
              status_d = rfd_pkg::ST_BAD_END;
            end
            phase_d = rfd_pkg::PH_HUNT;
          end
          rfd_pkg::PH_SKIP: begin
            if (pos_d >= len_q) begin
              phase_d = rfd_pkg::PH_HUNT;
            end
          end
          default: begin
            phase_d = rfd_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  // Result for the same byte.
  always_comb begin
    push = '0;
    if (stage_valid_i) begin
      case (phase_q)
        rfd_pkg::PH_ID, rfd_pkg::PH_METH, rfd_pkg::PH_EINFO, rfd_pkg::PH_PAYLOAD: begin
          push.valid        = 1'b1;
          push.res.data_out = stage_data_i;
          case (phase_q)
            rfd_pkg::PH_ID:    push.res.kind = rfd_pkg::KIND_MSG_ID;
            rfd_pkg::PH_METH:  push.res.kind = rfd_pkg::KIND_METHOD;
            rfd_pkg::PH_EINFO: push.res.kind = rfd_pkg::KIND_ERR_INFO;
            default:           push.res.kind = rfd_pkg::KIND_PAYLOAD;
          endcase
        end
        rfd_pkg::PH_ENDB, rfd_pkg::PH_SKIP: begin
          push.valid = (phase_q == rfd_pkg::PH_ENDB) || (pos_d >= len_q);
          push.res.kind         = rfd_pkg::KIND_FRAME_END;
          push.res.error_code   = err_q;
          push.res.frame_length = rfd_pkg::RFD_FLEN_W'(len_q);
          push.res.status       = status_d;
          push.res.last         = 1'b1;
        end
        default: begin
          push = '0;
        end
      endcase
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rfd_pkg::PH_HUNT;
      status_q <= rfd_pkg::ST_OK;
      word_q   <= '0;
      pos_q    <= '0;
      len_q    <= '0;
      left_q   <= '0;
      used_q   <= '0;
      err_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      status_q <= status_d;
      word_q   <= word_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      left_q   <= left_d;
      used_q   <= used_d;
      err_q    <= err_d;
    end
  end

  // Skipping only happens after a flagged field error.
  a_skip_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rfd_pkg::PH_SKIP) |-> (status_q == rfd_pkg::ST_OVERRUN ||
                                       status_q == rfd_pkg::ST_TOO_LONG))
    else $error("skip phase without a field error");

  // A skipped frame ends exactly at its last byte, never beyond.
  a_skip_before_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rfd_pkg::PH_SKIP) |-> (pos_q < len_q))
    else $error("frame position ran past frame length while skipping");

  // The frame length in use is never below the overhead when the end byte is reached.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rfd_pkg::PH_ENDB) |-> (len_q >= LEN_W'(rfd_pkg::RFD_OVERHEAD)))
    else $error("frame end reached with a frame length below the overhead");

endmodule

@@ hdl/rfd_out_buf.sv @@
// Small result queue of the RPC frame deframer that parts parser and result port.
// Depends on rfd_pkg.
module rfd_out_buf (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rfd_pkg::rfd_push_t                 push_i,
  input  logic                               pop_i,
  output logic                               valid_o,
  output rfd_pkg::rfd_result_t               head_o,
  output logic [rfd_pkg::RFD_BUF_LVL_W-1:0]  level_o
);

  localparam int DEPTH = rfd_pkg::RFD_BUF_DEPTH;
  localparam int PTR_W = rfd_pkg::RFD_BUF_PTR_W;
  localparam int LVL_W = rfd_pkg::RFD_BUF_LVL_W;

  rfd_pkg::rfd_result_t mem_q [DEPTH];
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic             do_pop;

  assign do_pop  = pop_i && (level_q != '0);
  assign valid_o = (level_q != '0);
  assign head_o  = mem_q[head_q];
  assign level_o = level_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    level_d = level_q;
    if (do_pop) begin
      head_d = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
    end
    if (push_i.valid) begin
      tail_d = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
    end
    case ({push_i.valid, do_pop})
      2'b10:   level_d = level_q + LVL_W'(1);
      2'b01:   level_d = level_q - LVL_W'(1);
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[tail_q] <= push_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
    end
  end

  // A push into a full queue would overwrite a waiting result.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.valid && !do_pop) |-> (level_q < LVL_W'(DEPTH)))
    else $error("result queue overflow");

endmodule

@@ hdl/rpc_frame_deframer.sv @@
// Top level of the RPC frame deframer: configuration registers, input stage, parser, queue.
// Depends on rfd_pkg, rfd_in_if, rfd_out_if, rfd_core and rfd_out_buf.
//
//   port       dir   handshake      carries
//   in_i       sink  valid/ready    data_in: one stream byte per item
//   out_o      src   valid/ready    kind, data_out, error_code, frame_length, status, last
//   APB        slv   psel/penable   start_byte at 0x0, end_byte at 0x4
//
// One byte is accepted per cycle while in_i.ready is high. An accepted byte is registered in the input stage, where
// the parser updates its phase and counters and writes any result into a three-entry queue;
// the result goes out on out_o when it reaches the head of the queue.
// Reset clears the parser to hunting for the start byte and sets start_byte to 2 and
// end_byte to 3; there is no clearing pass.
// in_i.ready falls only when the queue and the input stage together hold three items,
// which happens only while out_o is stalled.
//
// Frames are laid out as: start byte, 32-bit big-endian frame length, message-id length and
// bytes, method-name length and bytes, error code, error-info length and bytes, payload,
// four checksum bytes and the end byte. Every field byte gives one item with its kind tag;
// the last byte of a frame gives a frame-end item with error code, length and status.
// A frame length outside the legal range drops the frame silently and hunting resumes.
// After a field error the rest of the frame is swallowed up to its last byte.
module rpc_frame_deframer #(
  parameter int MAX_FRAME      = rfd_pkg::RFD_MAX_FRAME,
  parameter int MSG_ID_MAX     = rfd_pkg::RFD_MSG_ID_MAX,
  parameter int TEXT_FIELD_MAX = rfd_pkg::RFD_TEXT_FIELD_MAX
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfd_in_if.sink      in_i,
  rfd_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LVL_W = rfd_pkg::RFD_BUF_LVL_W;

  // Configuration registers. The register index is the word address.
  logic [7:0] start_q, start_d;
  logic [7:0] end_q, end_d;
  logic       cfg_wr;
  logic       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];
  assign prdata  = (cfg_idx == rfd_pkg::RFD_REG_START) ? {24'd0, start_q} : {24'd0, end_q};

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (cfg_wr) begin
      case (cfg_idx)
        rfd_pkg::RFD_REG_START: start_d = pwdata[7:0];
        rfd_pkg::RFD_REG_END:   end_d   = pwdata[7:0];
        default:                start_d = start_q;
      endcase
    end
  end

  // Input stage: the byte is held here while the parser works on it.
  logic       stage_valid_q;
  logic [7:0] stage_data_q;
  logic       in_ready;
  logic       in_fire;

  rfd_pkg::rfd_push_t   push;
  rfd_pkg::rfd_result_t head;
  logic                 buf_valid;
  logic [LVL_W-1:0]     buf_level;
  logic                 out_fire;

  // Room is reserved for the staged item and the new one before a byte is taken.
  assign in_ready = ((LVL_W + 1)'(buf_level) + (LVL_W + 1)'(stage_valid_q)) <=
                    (LVL_W + 1)'(rfd_pkg::RFD_BUF_DEPTH - 1);
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q       <= rfd_pkg::RFD_START_RST;
      end_q         <= rfd_pkg::RFD_END_RST;
      stage_valid_q <= 1'b0;
    end else begin
      start_q       <= start_d;
      end_q         <= end_d;
      stage_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_data_q <= in_i.data_in;
    end
  end

  rfd_core #(
    .MAX_FRAME      (MAX_FRAME),
    .MSG_ID_MAX     (MSG_ID_MAX),
    .TEXT_FIELD_MAX (TEXT_FIELD_MAX)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid_q),
    .stage_data_i  (stage_data_q),
    .start_byte_i  (start_q),
    .end_byte_i    (end_q),
    .push_o        (push)
  );

  rfd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .valid_o (buf_valid),
    .head_o  (head),
    .level_o (buf_level)
  );

  assign out_fire           = buf_valid && out_o.ready;
  assign out_o.valid        = buf_valid;
  assign out_o.kind         = head.kind;
  assign out_o.data_out     = head.data_out;
  assign out_o.error_code   = head.error_code;
  assign out_o.frame_length = head.frame_length;
  assign out_o.status       = head.status;
  assign out_o.last         = head.last;

  // A result only leaves the port through a completed handshake.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(buf_valid) |-> $past(out_fire))
    else $error("result vanished without handshake");

  // The queue plus the input stage never hold more than the queue can take.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q |-> (buf_level < LVL_W'(rfd_pkg::RFD_BUF_DEPTH)))
    else $error("staged item without room in result queue");

endmodule
